/* src/cir_pkg.sv */
// ============================================================================
// cir_pkg: shared types and constants for the contact impulse resolver
// Request and response payload structs, the pipeline context and stage map.
// ============================================================================
`default_nettype none

package cir_pkg;

   // One contact to resolve.
   typedef struct packed {
      logic signed [31:0] a_vel_x;
      logic signed [31:0] a_vel_y;
      logic signed [31:0] b_vel_x;
      logic signed [31:0] b_vel_y;
      logic [31:0]        a_mass;
      logic [31:0]        b_mass;
      logic [16:0]        a_restitution;
      logic [16:0]        b_restitution;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic [30:0]        depth;
   } req_type;

   // Resolved velocities and position pushes.
   typedef struct packed {
      logic signed [31:0] new_a_vel_x;
      logic signed [31:0] new_a_vel_y;
      logic signed [31:0] new_b_vel_x;
      logic signed [31:0] new_b_vel_y;
      logic signed [31:0] a_push_x;
      logic signed [31:0] a_push_y;
      logic signed [31:0] b_push_x;
      logic signed [31:0] b_push_y;
      logic               applied;
      logic               saturated;
   } rsp_type;

   // Everything one contact carries down the pipeline.
   typedef struct packed {
      logic signed [31:0] vax;
      logic signed [31:0] vay;
      logic signed [31:0] vbx;
      logic signed [31:0] vby;
      logic signed [32:0] rvx;
      logic signed [32:0] rvy;
      logic               a_inf;
      logic               b_inf;
      logic [17:0]        k;
      logic [32:0]        msum;
      logic [32:0]        md_rem;
      logic               md_feed;
      logic [16:0]        md_q;
      logic               nx_neg;
      logic               ny_neg;
      logic               nzero;
      logic [31:0]        ax;
      logic [31:0]        ay;
      logic [4:0]         shamt;
      logic [63:0]        sqx;
      logic [63:0]        sqy;
      logic [63:0]        sq_rad;
      logic [32:0]        sq_rem;
      logic [31:0]        sq_root;
      logic [31:0]        dx_rem;
      logic               dx_feed;
      logic [16:0]        qx;
      logic [31:0]        dy_rem;
      logic               dy_feed;
      logic [16:0]        qy;
      logic signed [63:0] pnx;
      logic signed [63:0] pny;
      logic signed [47:0] pax;
      logic signed [47:0] pay;
      logic signed [47:0] pbx;
      logic signed [47:0] pby;
      logic signed [17:0] hx;
      logic signed [17:0] hy;
      logic [16:0]        ra;
      logic [16:0]        rb;
      logic signed [50:0] prx;
      logic signed [50:0] pry;
      logic signed [51:0] dot;
      logic               go;
      logic signed [35:0] d16;
      logic signed [55:0] kd;
      logic signed [39:0] num;
      logic signed [57:0] jap;
      logic signed [57:0] jbp;
      logic signed [41:0] ja;
      logic signed [41:0] jb;
      logic signed [60:0] tax;
      logic signed [60:0] tay;
      logic signed [60:0] tbx;
      logic signed [60:0] tby;
      logic signed [47:0] nvax;
      logic signed [47:0] nvay;
      logic signed [47:0] nvbx;
      logic signed [47:0] nvby;
      rsp_type            rsp;
   } ctx_type;

   // Saturation result.
   typedef struct packed {
      logic               hit;
      logic signed [31:0] val;
   } sat_type;

   localparam logic [16:0] Q_ONE      = 17'd65536;
   localparam int          SQRT_STEPS = 32;
   localparam int          DIV_STEPS  = 17;

   // Stage map.
   localparam int ST_PREP    = 0;
   localparam int ST_LZC     = 1;
   localparam int ST_SHIFT   = 2;
   localparam int ST_SQUARE  = 3;
   localparam int ST_SUM     = 4;
   localparam int ST_SQRT    = 5;
   localparam int ST_NDIV    = ST_SQRT + SQRT_STEPS;
   localparam int ST_SIGN    = ST_NDIV + DIV_STEPS;
   localparam int ST_DOTMUL  = ST_SIGN + 1;
   localparam int ST_DOT     = ST_SIGN + 2;
   localparam int ST_D16     = ST_SIGN + 3;
   localparam int ST_KD      = ST_SIGN + 4;
   localparam int ST_NUM     = ST_SIGN + 5;
   localparam int ST_JMUL    = ST_SIGN + 6;
   localparam int ST_JRND    = ST_SIGN + 7;
   localparam int ST_TMUL    = ST_SIGN + 8;
   localparam int ST_ADD     = ST_SIGN + 9;
   localparam int ST_OUT     = ST_SIGN + 10;
   localparam int NUM_STAGES = ST_OUT + 1;

endpackage

`default_nettype wire

/* src/contact_impulse_resolver_top.sv */
// ============================================================================
// contact_impulse_resolver_top: pipelined 2D contact impulse resolver
// Normalizes the contact normal, forms the impulse from the smaller
// restitution and the mass shares, and returns new velocities and pushes.
// ============================================================================
//
//   Channel   Direction  Ports                              Moves
//   request   in         req_valid, req_stall, req_data     one contact
//   response  out        rsp_valid, rsp_stall, rsp_data     one resolved contact
//
// Every request gives exactly one response. A new request can enter in every
// cycle while req_stall is low; the depth is set by the 32-step square root
// of the normal's length followed by the 17-step divide that scales each
// normal component. The mass share divide runs beside the root.
// Reset clears only the stage valid bits; payload registers hold garbage
// until a request flows through. The whole pipeline holds while a response
// is waiting under rsp_stall, so req_stall is high exactly then.
//
`default_nettype none

module contact_impulse_resolver_top
   import cir_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // Pipeline registers: one context and one valid bit per stage.
   ctx_type                 pipe_ff [NUM_STAGES];
   ctx_type                 pipe_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]   valid_ff;
   logic [NUM_STAGES-1:0]   valid_in;
   logic                    advance;

   // Saturate a wide signed value to 32 bits and report a clamp.
   function automatic sat_type sat_fn(input logic signed [47:0] x);
      sat_type r;
      if (x > 48'sd2147483647) begin
         r.hit = 1'b1;
         r.val = 32'sh7FFFFFFF;
      end else if (x < -48'sd2147483648) begin
         r.hit = 1'b1;
         r.val = 32'sh80000000;
      end else begin
         r.hit = 1'b0;
         r.val = x[31:0];
      end
      return r;
   endfunction

   // The work of one stage. Stage zero builds the context from the request;
   // every other stage refines the context of the stage before it.
   function automatic ctx_type stage_fn(input int s, input ctx_type p, input req_type rq);
      ctx_type            c;
      logic [16:0]        e;
      logic signed [32:0] dep2;
      logic [31:0]        m;
      logic [4:0]         msb;
      logic [34:0]        t35;
      logic [34:0]        trial;
      logic [33:0]        t34;
      logic [33:0]        ms;
      logic [32:0]        tx;
      logic [32:0]        ty;
      logic [32:0]        lenx;
      logic               qb;
      sat_type            s0;
      sat_type            s1;
      sat_type            s2;
      sat_type            s3;
      sat_type            s4;
      sat_type            s5;
      c = p;
      if (s == ST_PREP) begin
         c = '0;
         c.vax = rq.a_vel_x;
         c.vay = rq.a_vel_y;
         c.vbx = rq.b_vel_x;
         c.vby = rq.b_vel_y;
         c.rvx = 33'(rq.b_vel_x) - 33'(rq.a_vel_x);
         c.rvy = 33'(rq.b_vel_y) - 33'(rq.a_vel_y);
         c.a_inf = (rq.a_mass == '0);
         c.b_inf = (rq.b_mass == '0);
         e = (rq.a_restitution < rq.b_restitution) ? rq.a_restitution : rq.b_restitution;
         c.k = {1'b0, e} + {1'b0, Q_ONE};
         c.msum = {1'b0, rq.a_mass} + {1'b0, rq.b_mass};
         c.md_rem = {2'b00, rq.a_mass[31:1]};
         c.md_feed = rq.a_mass[0];
         c.nx_neg = rq.normal_x[31];
         c.ny_neg = rq.normal_y[31];
         c.ax = rq.normal_x[31] ? (~$unsigned(rq.normal_x) + 32'd1) : $unsigned(rq.normal_x);
         c.ay = rq.normal_y[31] ? (~$unsigned(rq.normal_y) + 32'd1) : $unsigned(rq.normal_y);
         c.nzero = (rq.normal_x == '0) && (rq.normal_y == '0);
         dep2 = $signed({1'b0, rq.depth, 1'b0});
         c.pnx = 64'(dep2) * 64'(rq.normal_x);
         c.pny = 64'(dep2) * 64'(rq.normal_y);
      end
      if (s == ST_LZC) begin
         m = (p.ax > p.ay) ? p.ax : p.ay;
         msb = '0;
         for (int i = 0; i < 30; i++) begin
            if (m[i]) begin
               msb = 5'(i);
            end
         end
         c.shamt = (m[31] || m[30]) ? 5'd0 : (5'd30 - msb);
         c.pbx = 48'((p.pnx + 64'sd32768) >>> 16);
         c.pby = 48'((p.pny + 64'sd32768) >>> 16);
         c.pax = 48'((-p.pnx + 64'sd32768) >>> 16);
         c.pay = 48'((-p.pny + 64'sd32768) >>> 16);
      end
      if (s == ST_SHIFT) begin
         c.ax = p.ax << p.shamt;
         c.ay = p.ay << p.shamt;
         c.dx_rem = {1'b0, c.ax[31:1]};
         c.dx_feed = c.ax[0];
         c.dy_rem = {1'b0, c.ay[31:1]};
         c.dy_feed = c.ay[0];
      end
      if (s == ST_SQUARE) begin
         c.sqx = 64'(p.ax) * 64'(p.ax);
         c.sqy = 64'(p.ay) * 64'(p.ay);
      end
      if (s == ST_SUM) begin
         c.sq_rad = p.sqx + p.sqy;
         c.sq_rem = '0;
         c.sq_root = '0;
      end
      if (s >= ST_SQRT && s < ST_SQRT + SQRT_STEPS) begin
         t35 = {p.sq_rem, p.sq_rad[63:62]};
         trial = {1'b0, p.sq_root, 2'b01};
         if (t35 >= trial) begin
            c.sq_rem = 33'(t35 - trial);
            c.sq_root = {p.sq_root[30:0], 1'b1};
         end else begin
            c.sq_rem = t35[32:0];
            c.sq_root = {p.sq_root[30:0], 1'b0};
         end
         c.sq_rad = {p.sq_rad[61:0], 2'b00};
      end
      if (s >= ST_SQRT && s < ST_SQRT + DIV_STEPS) begin
         t34 = {p.md_rem, p.md_feed};
         ms = {1'b0, p.msum};
         qb = (t34 >= ms);
         c.md_rem = qb ? 33'(t34 - ms) : t34[32:0];
         c.md_q = {p.md_q[15:0], qb};
         c.md_feed = 1'b0;
      end
      if (s >= ST_NDIV && s < ST_NDIV + DIV_STEPS) begin
         lenx = {1'b0, p.sq_root};
         tx = {p.dx_rem, p.dx_feed};
         ty = {p.dy_rem, p.dy_feed};
         c.dx_rem = (tx >= lenx) ? 32'(tx - lenx) : tx[31:0];
         c.qx = {p.qx[15:0], (tx >= lenx)};
         c.dx_feed = 1'b0;
         c.dy_rem = (ty >= lenx) ? 32'(ty - lenx) : ty[31:0];
         c.qy = {p.qy[15:0], (ty >= lenx)};
         c.dy_feed = 1'b0;
      end
      if (s == ST_SIGN) begin
         c.hx = p.nzero ? 18'sd0 :
                (p.nx_neg ? -$signed({1'b0, p.qx}) : $signed({1'b0, p.qx}));
         c.hy = p.nzero ? 18'sd0 :
                (p.ny_neg ? -$signed({1'b0, p.qy}) : $signed({1'b0, p.qy}));
         c.rb = p.a_inf ? Q_ONE : (p.b_inf ? 17'd0 : p.md_q);
         c.ra = Q_ONE - c.rb;
      end
      if (s == ST_DOTMUL) begin
         c.prx = 51'(p.rvx) * 51'(p.hx);
         c.pry = 51'(p.rvy) * 51'(p.hy);
      end
      if (s == ST_DOT) begin
         c.dot = 52'(p.prx) + 52'(p.pry);
      end
      if (s == ST_D16) begin
         c.d16 = 36'((p.dot + 52'sd32768) >>> 16);
         c.go = !(p.a_inf && p.b_inf) && (p.dot <= 52'sd0);
      end
      if (s == ST_KD) begin
         c.kd = -(56'($signed({1'b0, p.k})) * 56'(p.d16));
      end
      if (s == ST_NUM) begin
         c.num = 40'((p.kd + 56'sd32768) >>> 16);
      end
      if (s == ST_JMUL) begin
         c.jap = 58'(p.num) * 58'($signed({1'b0, p.ra}));
         c.jbp = 58'(p.num) * 58'($signed({1'b0, p.rb}));
      end
      if (s == ST_JRND) begin
         c.ja = 42'((p.jap + 58'sd32768) >>> 16);
         c.jb = 42'((p.jbp + 58'sd32768) >>> 16);
      end
      if (s == ST_TMUL) begin
         c.tax = -(61'(p.ja) * 61'(p.hx));
         c.tay = -(61'(p.ja) * 61'(p.hy));
         c.tbx = 61'(p.jb) * 61'(p.hx);
         c.tby = 61'(p.jb) * 61'(p.hy);
      end
      if (s == ST_ADD) begin
         c.nvax = 48'(p.vax) + 48'((p.tax + 61'sd32768) >>> 16);
         c.nvay = 48'(p.vay) + 48'((p.tay + 61'sd32768) >>> 16);
         c.nvbx = 48'(p.vbx) + 48'((p.tbx + 61'sd32768) >>> 16);
         c.nvby = 48'(p.vby) + 48'((p.tby + 61'sd32768) >>> 16);
      end
      if (s == ST_OUT) begin
         c.rsp = '0;
         s0 = sat_fn(p.nvax);
         s1 = sat_fn(p.nvay);
         s2 = sat_fn(p.nvbx);
         s3 = sat_fn(p.nvby);
         if (p.go) begin
            c.rsp.new_a_vel_x = s0.val;
            c.rsp.new_a_vel_y = s1.val;
            c.rsp.new_b_vel_x = s2.val;
            c.rsp.new_b_vel_y = s3.val;
            c.rsp.applied = 1'b1;
            c.rsp.saturated = s0.hit | s1.hit | s2.hit | s3.hit;
            if (p.a_inf) begin
               s4 = sat_fn(p.pbx);
               s5 = sat_fn(p.pby);
               c.rsp.b_push_x = s4.val;
               c.rsp.b_push_y = s5.val;
               c.rsp.saturated = c.rsp.saturated | s4.hit | s5.hit;
            end else if (p.b_inf) begin
               s4 = sat_fn(p.pax);
               s5 = sat_fn(p.pay);
               c.rsp.a_push_x = s4.val;
               c.rsp.a_push_y = s5.val;
               c.rsp.saturated = c.rsp.saturated | s4.hit | s5.hit;
            end
         end else begin
            // Separating contact or two static bodies: pass through.
            c.rsp.new_a_vel_x = p.vax;
            c.rsp.new_a_vel_y = p.vay;
            c.rsp.new_b_vel_x = p.vbx;
            c.rsp.new_b_vel_y = p.vby;
         end
      end
      return c;
   endfunction

   // The pipeline moves as one unit whenever the output register is empty or
   // its response is being taken. Bubbles travel as cleared valid bits.
   assign advance   = !valid_ff[NUM_STAGES-1] || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      ctx_type prev;
      for (int s = 0; s < NUM_STAGES; s++) begin
         if (s == 0) begin
            prev = pipe_ff[0];
         end else begin
            prev = pipe_ff[s-1];
         end
         pipe_in[s] = stage_fn(s, prev, req_data);
      end
      valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};
   end

   // Valid bits are control state and reset; the contexts need none.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff <= pipe_in;
      end
   end

   // The last stage is the output register.
   assign rsp_valid = valid_ff[NUM_STAGES-1];
   assign rsp_data  = pipe_ff[NUM_STAGES-1].rsp;

endmodule

`default_nettype wire

/* src/cir_checker.sv */
// ============================================================================
// cir_checker: port-level checks for the contact impulse resolver
// Watches both channels of the top level and is bound to it.
// ============================================================================
`default_nettype none

module cir_checker
   import cir_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // A response held under stall keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Requests are refused only while a finished response waits.
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with no waiting response");

   // A skipped contact has no pushes and no clamp.
   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.applied |->
         !rsp_data.saturated && rsp_data.a_push_x == '0 && rsp_data.a_push_y == '0 &&
         rsp_data.b_push_x == '0 && rsp_data.b_push_y == '0)
      else $error("skipped contact reports push or clamp");

   // At most one body is pushed.
   a_one_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.a_push_x == '0 && rsp_data.a_push_y == '0) ||
                    (rsp_data.b_push_x == '0 && rsp_data.b_push_y == '0))
      else $error("both bodies pushed");

endmodule

bind contact_impulse_resolver_top cir_checker u_cir_checker (.*);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ============================================================================
// Contact impulse resolver testbench
// Drives directed and random contacts through the request channel, predicts
// each resolved contact in a bit-exact fixed-point model and compares every
// response field by field, with random idling and a long response hold-off.
// ============================================================================
`default_nettype none

module testbench;
   import cir_pkg::*;

   localparam int RANDOM_COUNT = 1530;
   localparam int QUIET_TAIL   = 200;
   localparam int WATCHDOG     = 5000;
   localparam int LATENCY      = 65;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Expected resolved contacts, oldest first.
   rsp_type resolved_q[$];
   int      error_count;
   int      idle_cycles;
   int      accepted_count;
   int      response_count;
   bit      quiet;
   bit      hold_off;
   bit      stimulus_done;

   contact_impulse_resolver_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Floor of x / 65536 after adding one half, which rounds half up.
   function automatic longint round16(longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   // Clamp to the signed 32-bit range and note whether it clamped.
   function automatic logic [31:0] clamp32(longint x, ref bit hit);
      if (x > 64'sd2147483647) begin
         hit = 1'b1;
         return 32'h7fff_ffff;
      end
      if (x < -64'sd2147483648) begin
         hit = 1'b1;
         return 32'h8000_0000;
      end
      return x[31:0];
   endfunction

   // Integer square root by the digit-by-digit method.
   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Resolves one contact the way the hardware must.
   function automatic rsp_type resolve_contact(req_type c);
      rsp_type o;
      longint vax, vay, vbx, vby, nx, ny, dep;
      longint unsigned ma, mb, ea, eb, ax, ay, m, len;
      longint hx, hy, dot, e, d16, num, rb, ra, ja, jb;
      bit hit;
      vax = c.a_vel_x;
      vay = c.a_vel_y;
      vbx = c.b_vel_x;
      vby = c.b_vel_y;
      nx  = c.normal_x;
      ny  = c.normal_y;
      dep = longint'({33'd0, c.depth});
      ma  = {32'd0, c.a_mass};
      mb  = {32'd0, c.b_mass};
      ea  = {47'd0, c.a_restitution};
      eb  = {47'd0, c.b_restitution};
      hit = 1'b0;
      o = '0;
      o.new_a_vel_x = c.a_vel_x;
      o.new_a_vel_y = c.a_vel_y;
      o.new_b_vel_x = c.b_vel_x;
      o.new_b_vel_y = c.b_vel_y;
      if (!(ma == 0 && mb == 0)) begin
         ax = nx < 0 ? -nx : nx;
         ay = ny < 0 ? -ny : ny;
         if (ax == 0 && ay == 0) begin
            hx = 0;
            hy = 0;
         end else begin
            m = ax > ay ? ax : ay;
            while (m < (64'd1 << 30)) begin
               ax = ax << 1;
               ay = ay << 1;
               m  = m << 1;
            end
            len = root64(ax * ax + ay * ay);
            hx = longint'((ax << 16) / len);
            hy = longint'((ay << 16) / len);
            if (nx < 0) hx = -hx;
            if (ny < 0) hy = -hy;
         end
         dot = (vbx - vax) * hx + (vby - vay) * hy;
         if (dot <= 0) begin
            e   = longint'(ea < eb ? ea : eb);
            d16 = round16(dot);
            num = round16(-((64'sd65536 + e) * d16));
            if (ma == 0) rb = 64'sd65536;
            else if (mb == 0) rb = 0;
            else rb = longint'((ma << 16) / (ma + mb));
            ra = 64'sd65536 - rb;
            ja = round16(num * ra);
            jb = round16(num * rb);
            o.new_a_vel_x = clamp32(vax + round16(-ja * hx), hit);
            o.new_a_vel_y = clamp32(vay + round16(-ja * hy), hit);
            o.new_b_vel_x = clamp32(vbx + round16(jb * hx), hit);
            o.new_b_vel_y = clamp32(vby + round16(jb * hy), hit);
            if (ma == 0) begin
               o.b_push_x = clamp32(round16(dep * 2 * nx), hit);
               o.b_push_y = clamp32(round16(dep * 2 * ny), hit);
            end else if (mb == 0) begin
               o.a_push_x = clamp32(round16(-(dep * 2 * nx)), hit);
               o.a_push_y = clamp32(round16(-(dep * 2 * ny)), hit);
            end
            o.applied = 1'b1;
         end
      end
      o.saturated = hit;
      return o;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0008_0000)
                                        : -$urandom_range(0, 32'h0008_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_mass();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hffff_ffff;
         2, 3: return $urandom_range(1, 32'h0010_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [16:0] rand_restitution();
      case ($urandom_range(0, 5))
         0: return 17'd65536;
         1: return 17'd0;
         2: return 17'h1_ffff;
         default: return $urandom_range(0, 65536);
      endcase
   endfunction

   function automatic req_type random_contact();
      req_type c;
      c.a_vel_x       = rand_word();
      c.a_vel_y       = rand_word();
      c.b_vel_x       = rand_word();
      c.b_vel_y       = rand_word();
      c.a_mass        = rand_mass();
      c.b_mass        = rand_mass();
      c.a_restitution = rand_restitution();
      c.b_restitution = rand_restitution();
      c.normal_x      = $urandom_range(0, 9) == 0 ? 32'd0 : rand_word();
      c.normal_y      = $urandom_range(0, 9) == 0 ? 32'd0 : rand_word();
      c.depth         = $urandom_range(0, 3) == 0 ? 31'h7fff_ffff
                                                  : 31'($urandom_range(0, 32'h0004_0000));
      // Most contacts are made to approach so the impulse path is taken.
      if ($urandom_range(0, 3) != 0) begin
         c.b_vel_x = -c.a_vel_x;
         c.b_vel_y = -c.a_vel_y;
         c.normal_x = c.a_vel_x;
         c.normal_y = c.a_vel_y;
      end
      return c;
   endfunction

   // One row of the directed table: the contact, and when known at a
   // glance, the response typed in.
   typedef struct {
      req_type contact;
      bit      known;
      rsp_type answer;
   } row_type;

   row_type directed[$];

   function automatic req_type make_contact(logic [31:0] vax, logic [31:0] vay,
                                            logic [31:0] vbx, logic [31:0] vby,
                                            logic [31:0] ma, logic [31:0] mb,
                                            logic [16:0] ea, logic [16:0] eb,
                                            logic [31:0] nx, logic [31:0] ny,
                                            logic [30:0] dep);
      req_type c;
      c = '{vax, vay, vbx, vby, ma, mb, ea, eb, nx, ny, dep};
      return c;
   endfunction

   task automatic add_row(req_type c, bit known, rsp_type answer);
      row_type r;
      r.contact = c;
      r.known   = known;
      r.answer  = answer;
      directed.push_back(r);
   endtask

   task automatic build_table();
      req_type c;
      rsp_type a;
      // Both masses infinite: everything passes through, nothing applied.
      c = make_contact(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'hffff_0000,
                       32'd0, 32'd0, 17'd65536, 17'd0, 32'h0001_0000, 32'd0, 31'd5);
      a = '0;
      a.new_a_vel_x = 32'h7fff_ffff;
      a.new_a_vel_y = 32'h8000_0000;
      a.new_b_vel_x = 32'h0001_0000;
      a.new_b_vel_y = 32'hffff_0000;
      add_row(c, 1'b1, a);
      // Separating along +x: B moves away from A.
      c = make_contact(32'd0, 32'd0, 32'h0001_0000, 32'd0,
                       32'h0001_0000, 32'h0001_0000, 17'd0, 17'd0,
                       32'h0001_0000, 32'd0, 31'd0);
      a = '0;
      a.new_b_vel_x = 32'h0001_0000;
      add_row(c, 1'b1, a);
      // Zero normal: applied with no change.
      c = make_contact(32'h0002_0000, 32'h0003_0000, 32'h8000_0000, 32'h7fff_ffff,
                       32'h0001_0000, 32'd0, 17'd65536, 17'd65536,
                       32'd0, 32'd0, 31'h7fff_ffff);
      a = '0;
      a.new_a_vel_x = 32'h0002_0000;
      a.new_a_vel_y = 32'h0003_0000;
      a.new_b_vel_x = 32'h8000_0000;
      a.new_b_vel_y = 32'h7fff_ffff;
      a.applied = 1'b1;
      add_row(c, 1'b1, a);
      // Head-on, equal masses, B static, A static, full and over-unity bounce.
      add_row(make_contact(32'h0001_0000, 0, 32'hffff_0000, 0, 32'h0001_0000,
                           32'h0001_0000, 17'd65536, 17'd65536, 32'h0001_0000, 0, 31'd0),
              1'b0, '0);
      add_row(make_contact(32'h0001_0000, 0, 0, 0, 32'h0002_0000, 32'd0,
                           17'd32768, 17'd65536, 32'h0001_0000, 0, 31'h0000_8000),
              1'b0, '0);
      add_row(make_contact(0, 0, 0, 32'hfffe_0000, 32'd0, 32'h0003_0000,
                           17'd0, 17'd65536, 0, 32'h0001_0000, 31'h0001_0000),
              1'b0, '0);
      add_row(make_contact(32'h0000_4000, 32'h0000_4000, 0, 0, 32'h1234_5678,
                           32'h0000_0001, 17'h1_ffff, 17'h1_ffff, 32'h7fff_ffff,
                           32'h7fff_ffff, 31'd100), 1'b0, '0);
      // Saturating velocities and pushes at the extremes.
      add_row(make_contact(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                           32'hffff_ffff, 32'd0, 17'h1_ffff, 17'h1_ffff,
                           32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff), 1'b0, '0);
      add_row(make_contact(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                           32'd0, 32'hffff_ffff, 17'h1_ffff, 17'h1_ffff,
                           32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff), 1'b0, '0);
      add_row(make_contact(32'h8000_0000, 0, 32'h7fff_ffff, 0, 32'hffff_ffff,
                           32'hffff_ffff, 17'd65536, 17'd0, 32'h8000_0000, 32'd1,
                           31'h7fff_ffff), 1'b0, '0);
      add_row(make_contact(32'hffff_ffff, 32'h0000_0001, 32'd0, 32'd0, 32'd1, 32'd1,
                           17'd1, 17'd2, 32'd1, 32'hffff_ffff, 31'd1), 1'b0, '0);
      add_row(make_contact(32'h0005_0000, 32'hfffb_0000, 0, 0, 32'd0, 32'h0001_0000,
                           17'd65536, 17'd65536, 32'h0003_0000, 32'hfffc_0000,
                           31'h0002_0000), 1'b0, '0);
   endtask

   task automatic send(req_type c);
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accepted_count++;
      @(negedge clock);
      // Random gaps between requests, none in the quiet tail.
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         req_data  <= random_contact();
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   initial begin
      req_type c;
      error_count    = 0;
      accepted_count = 0;
      response_count = 0;
      quiet          = 1'b0;
      hold_off       = 1'b0;
      stimulus_done  = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      build_table();
      repeat (9) @(negedge clock);
      reset = 1'b0;
      foreach (directed[i]) begin
         resolved_q.push_back(directed[i].known ? directed[i].answer
                                                : resolve_contact(directed[i].contact));
         send(directed[i].contact);
      end
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (n == RANDOM_COUNT - QUIET_TAIL) quiet = 1'b1;
         // A long response hold-off lets the pipeline fill and back up.
         if (n == 400) hold_off = 1'b1;
         c = random_contact();
         resolved_q.push_back(resolve_contact(c));
         send(c);
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Response side: random stall bursts, one long hold-off.
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (150) @(negedge clock);
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end else begin
            @(negedge clock);
         end
      end
   end

   // Compare every accepted response against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         response_count++;
         if (resolved_q.size() == 0) begin
            $display("%0t: unexpected response %h", $realtime, rsp_data);
            error_count++;
         end else begin
            want = resolved_q.pop_front();
            if (want !== rsp_data) begin
               error_count++;
               $display("%0t: mismatch expected %h actual %h", $realtime, want, rsp_data);
               $display("   vel a x/y exp %h %h act %h %h", want.new_a_vel_x,
                        want.new_a_vel_y, rsp_data.new_a_vel_x, rsp_data.new_a_vel_y);
               $display("   vel b x/y exp %h %h act %h %h", want.new_b_vel_x,
                        want.new_b_vel_y, rsp_data.new_b_vel_x, rsp_data.new_b_vel_y);
               $display("   push a exp %h %h act %h %h", want.a_push_x, want.a_push_y,
                        rsp_data.a_push_x, rsp_data.a_push_y);
               $display("   push b exp %h %h act %h %h", want.b_push_x, want.b_push_y,
                        rsp_data.b_push_x, rsp_data.b_push_y);
               $display("   applied/sat exp %b%b act %b%b", want.applied, want.saturated,
                        rsp_data.applied, rsp_data.saturated);
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // A run that stops making progress at any point ends here.
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("%0t: watchdog expired after %0d idle cycles", $realtime, idle_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      wait (stimulus_done);
      while (resolved_q.size() != 0 && idle_cycles < WATCHDOG) @(posedge clock);
      if (resolved_q.size() != 0) begin
         $display("Timeout with %0d responses outstanding", resolved_q.size());
         $display("Some tests failed");
      end else begin
         repeat (LATENCY + 10) @(posedge clock);
         $display("Ran %0d contacts and checked %0d responses, %0d errors.",
                  accepted_count, response_count, error_count);
         if (error_count == 0)
            $display("All tests passed");
         else
            $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
src/cir_pkg.sv
src/contact_impulse_resolver_top.sv
src/cir_checker.sv
bench/testbench.sv
